### rtl/core/mtfs_pkg.sv
// ----------------------------------------------------------------------------
// mtfs_pkg
// Shared types, widths and reset values for the motor test-fire sequencer.
// ----------------------------------------------------------------------------
package mtfs_pkg;

    localparam int LOAD_BITS   = 24;
    localparam int AVG_WINDOW  = 50;
    localparam int THR_BITS    = 24;
    localparam int CNT_BITS    = 20;
    localparam int IVL_BITS    = 10;
    localparam int PHASE_BITS  = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam int POS_W    = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
    localparam int FILL_W   = $clog2(AVG_WINDOW + 1);
    localparam int CMP_BITS = (LOAD_BITS > THR_BITS) ? LOAD_BITS : THR_BITS;
    localparam int SUM_W    = CMP_BITS + FILL_W + 1;

    localparam logic [CNT_BITS-1:0]        COUNTDOWN_RST = CNT_BITS'(30000);
    localparam logic signed [THR_BITS-1:0] THRESHOLD_RST = THR_BITS'(10);
    localparam logic [CNT_BITS-1:0]        DATA_SAFE_RST = CNT_BITS'(0);
    localparam logic [IVL_BITS-1:0]        SLOW_IVL_RST  = IVL_BITS'(100);
    localparam logic [IVL_BITS-1:0]        FAST_IVL_RST  = IVL_BITS'(10);

    typedef enum logic [PHASE_BITS-1:0] {
        PH_STANDBY   = 3'd0,
        PH_COUNTDOWN = 3'd1,
        PH_IGNITION  = 3'd2,
        PH_BURN      = 3'd3,
        PH_SAFE      = 3'd4,
        PH_ENDED     = 3'd5,
        PH_ABORT     = 3'd6
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COUNTDOWN = 3'd0,
        REG_THRESHOLD = 3'd1,
        REG_DATA_SAFE = 3'd2,
        REG_SLOW_IVL  = 3'd3,
        REG_FAST_IVL  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [CNT_BITS-1:0]        countdown_ms;
        logic signed [THR_BITS-1:0] load_threshold;
        logic [CNT_BITS-1:0]        data_safe_ms;
        logic [IVL_BITS-1:0]        log_interval_slow_ms;
        logic [IVL_BITS-1:0]        log_interval_fast_ms;
    } cfg_t;

    typedef struct packed {
        phase_t              phase;
        logic                pyro_fire;
        logic                log_enable;
        logic [IVL_BITS-1:0] log_interval_ms;
    } result_t;

endpackage

### rtl/core/motor_test_fire_sequencer.sv
// ----------------------------------------------------------------------------
// motor_test_fire_sequencer
// Test-stand fire sequencer: one load tick in, one phase/pyro/log result out.
// ----------------------------------------------------------------------------
// Each transfer on the s_ channel is one 1 ms tick and yields exactly one
// result on the m_ channel, held there until m_ready is high:
// the tick is held in an input register, then the phase logic and the
// running-average window compute the result into an output register. A new
// tick is taken every clock; s_ready drops only while both registers hold
// data and the result is not being taken. The average window is a 50-entry
// memory whose oldest entry is prefetched and dropped only once the window
// is full, so no clearing pass is needed after reset. Configuration writes
// are taken on any cycle and should be made while no tick is in flight.
module motor_test_fire_sequencer
    import mtfs_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [LOAD_BITS-1:0] s_load,
    input  logic                        s_arm,
    input  logic                        s_abort,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [PHASE_BITS-1:0]       m_phase,
    output logic                        m_pyro_fire,
    output logic                        m_log_enable,
    output logic [IVL_BITS-1:0]         m_log_interval_ms
);

    cfg_t    cfg;
    result_t result;
    result_t res_reg;
    logic    in_valid_reg, in_valid_next;
    logic    out_valid_reg, out_valid_next;
    logic    advance;
    logic    window_below;
    logic    window_update;
    logic signed [LOAD_BITS-1:0] load_reg;
    logic    arm_reg;
    logic    abort_reg;

    mtfs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mtfs_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .update  (window_update),
        .sample  (load_reg),
        .thr     (cfg.load_threshold),
        .below   (window_below)
    );

    mtfs_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .load          (load_reg),
        .arm           (arm_reg),
        .abort         (abort_reg),
        .cfg           (cfg),
        .window_below  (window_below),
        .window_update (window_update),
        .result        (result)
    );

    // move the held tick forward whenever the result slot is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign in_valid_next  = (s_valid && s_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            load_reg  <= s_load;
            arm_reg   <= s_arm;
            abort_reg <= s_abort;
        end
        if (advance) begin
            res_reg <= result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_phase           = res_reg.phase;
    assign m_pyro_fire       = res_reg.pyro_fire;
    assign m_log_enable      = res_reg.log_enable;
    assign m_log_interval_ms = res_reg.log_interval_ms;

endmodule

### rtl/core/mtfs_cfg_regs.sv
// ----------------------------------------------------------------------------
// mtfs_cfg_regs
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module mtfs_cfg_regs
    import mtfs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                REG_COUNTDOWN: cfg_next.countdown_ms         = cfg_data[CNT_BITS-1:0];
                REG_THRESHOLD: cfg_next.load_threshold       = cfg_data[THR_BITS-1:0];
                REG_DATA_SAFE: cfg_next.data_safe_ms         = cfg_data[CNT_BITS-1:0];
                REG_SLOW_IVL:  cfg_next.log_interval_slow_ms = cfg_data[IVL_BITS-1:0];
                REG_FAST_IVL:  cfg_next.log_interval_fast_ms = cfg_data[IVL_BITS-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.countdown_ms         <= COUNTDOWN_RST;
            cfg_reg.load_threshold       <= THRESHOLD_RST;
            cfg_reg.data_safe_ms         <= DATA_SAFE_RST;
            cfg_reg.log_interval_slow_ms <= SLOW_IVL_RST;
            cfg_reg.log_interval_fast_ms <= FAST_IVL_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/core/mtfs_window.sv
// ----------------------------------------------------------------------------
// mtfs_window
// Running-sum average over the last AVG_WINDOW burn samples, compared
// against the threshold as sum < threshold * count.
// ----------------------------------------------------------------------------
module mtfs_window
    import mtfs_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        update,
    input  logic signed [LOAD_BITS-1:0] sample,
    input  logic signed [THR_BITS-1:0]  thr,
    output logic                        below
);

    logic signed [LOAD_BITS-1:0] window_mem [AVG_WINDOW];
    logic signed [LOAD_BITS-1:0] oldest_reg;

    logic [POS_W-1:0]        pos_reg, pos_next, pos_upd, rd_addr;
    logic [FILL_W-1:0]       fill_reg, fill_next, fill_upd;
    logic signed [SUM_W-1:0] sum_reg, sum_next, sum_upd;
    logic signed [SUM_W-1:0] oldest_ext;
    logic signed [THR_BITS+FILL_W:0] prod;
    logic                    full;

    assign full     = (fill_reg == FILL_W'(AVG_WINDOW));
    assign fill_upd = full ? fill_reg : fill_reg + FILL_W'(1);
    assign pos_upd  = (pos_reg == POS_W'(AVG_WINDOW - 1)) ? '0 : pos_reg + POS_W'(1);

    // drop the oldest sample only once the window is full
    assign oldest_ext = full ? SUM_W'(oldest_reg) : '0;
    assign sum_upd    = sum_reg - oldest_ext + SUM_W'(sample);
    assign prod       = thr * $signed({1'b0, fill_upd});
    assign below      = (sum_upd < SUM_W'(prod));

    assign pos_next  = update ? pos_upd  : pos_reg;
    assign fill_next = update ? fill_upd : fill_reg;
    assign sum_next  = update ? sum_upd  : sum_reg;

    // prefetch the entry at the next write position
    assign rd_addr = pos_next;

    always_ff @(posedge aclk) begin
        if (update) begin
            window_mem[pos_reg] <= sample;
        end
        if (update && (rd_addr == pos_reg)) begin
            oldest_reg <= sample;
        end else begin
            oldest_reg <= window_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
        end else begin
            pos_reg  <= pos_next;
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
        end
    end

endmodule

### rtl/core/mtfs_core.sv
// ----------------------------------------------------------------------------
// mtfs_core
// Phase state machine: countdown and data-safe timers, arm latch, logging
// mode, and the result for each transfer.
// ----------------------------------------------------------------------------
module mtfs_core
    import mtfs_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic signed [LOAD_BITS-1:0] load,
    input  logic                        arm,
    input  logic                        abort,
    input  cfg_t                        cfg,
    input  logic                        window_below,
    output logic                        window_update,
    output result_t                     result
);

    phase_t              phase_reg, phase_next;
    logic                arm_latch_reg, arm_latch_next;
    logic [CNT_BITS-1:0] countdown_reg, countdown_next;
    logic [CNT_BITS-1:0] safe_reg, safe_next;
    logic                fast_reg, fast_next;
    logic                load_high;

    assign load_high     = (CMP_BITS'(load) > CMP_BITS'(cfg.load_threshold));
    assign window_update = advance && !abort && (phase_reg == PH_BURN);

    always_comb begin
        phase_next     = phase_reg;
        arm_latch_next = arm_latch_reg;
        countdown_next = countdown_reg;
        safe_next      = safe_reg;
        fast_next      = fast_reg;
        if (advance) begin
            arm_latch_next = arm_latch_reg | arm;
            if (abort) begin
                phase_next = PH_ABORT;
            end else begin
                case (phase_reg)
                    PH_STANDBY: begin
                        if (arm_latch_reg || arm) begin
                            countdown_next = cfg.countdown_ms;
                            phase_next     = PH_COUNTDOWN;
                        end
                    end
                    PH_COUNTDOWN: begin
                        if (countdown_reg == '0) begin
                            phase_next = PH_IGNITION;
                        end else begin
                            countdown_next = countdown_reg - CNT_BITS'(1);
                        end
                    end
                    PH_IGNITION: begin
                        fast_next = 1'b1;
                        if (load_high) begin
                            phase_next = PH_BURN;
                        end
                    end
                    PH_BURN: begin
                        if (window_below) begin
                            safe_next  = cfg.data_safe_ms;
                            phase_next = PH_SAFE;
                        end
                    end
                    PH_SAFE: begin
                        // high load wins over an expired timer
                        if (load_high) begin
                            phase_next = PH_BURN;
                        end else if (safe_reg == '0) begin
                            phase_next = PH_ENDED;
                        end else begin
                            safe_next = safe_reg - CNT_BITS'(1);
                        end
                    end
                    default: phase_next = phase_reg;
                endcase
            end
        end
    end

    always_comb begin
        result.phase           = phase_next;
        result.pyro_fire       = !abort && (phase_reg == PH_IGNITION);
        result.log_enable      = (phase_next == PH_COUNTDOWN) || (phase_next == PH_IGNITION)
                              || (phase_next == PH_BURN) || (phase_next == PH_SAFE);
        result.log_interval_ms = fast_next ? cfg.log_interval_fast_ms
                                           : cfg.log_interval_slow_ms;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_STANDBY;
            arm_latch_reg <= 1'b0;
            countdown_reg <= '0;
            safe_reg      <= '0;
            fast_reg      <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            arm_latch_reg <= arm_latch_next;
            countdown_reg <= countdown_next;
            safe_reg      <= safe_next;
            fast_reg      <= fast_next;
        end
    end

endmodule

### sim/tb_motor_test_fire_sequencer.sv
// ----------------------------------------------------------------------------
// tb_motor_test_fire_sequencer
// Self-checking bench for the motor test-fire sequencer. A directed plan walks
// standby, arming, countdown, ignition and burn/data-safe hand-over. Random
// phases with fresh register settings then keep the block cycling between
// burn and data-safe. The run finishes by ending the firing and aborting.
// Every tick is predicted by a cycle-free model of the phase logic and the
// running-sum window, and each result is compared field by field.
// ----------------------------------------------------------------------------
module tb_motor_test_fire_sequencer;
    import mtfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     PHASE_TICKS  = 150;
    localparam int     RAND_PHASES  = 10;
    localparam int     LONG_HOLD    = 300;
    localparam int     DRAIN_CYCLES = 4;
    localparam longint TIMEOUT_NS   = 10_000_000;

    localparam longint LOAD_MAX = (longint'(1) << (LOAD_BITS - 1)) - 1;
    localparam longint LOAD_MIN = -(longint'(1) << (LOAD_BITS - 1));
    localparam logic signed [LOAD_BITS-1:0] LOAD_TOP    = 24'sh7FFFFF;
    localparam logic signed [LOAD_BITS-1:0] LOAD_BOTTOM = 24'sh800000;

    localparam result_t NO_WANT    = '{PH_STANDBY, 1'b0, 1'b0, 10'd0};
    localparam result_t WANT_IDLE  = '{PH_STANDBY, 1'b0, 1'b0, 10'd100};
    localparam result_t WANT_ARMED = '{PH_COUNTDOWN, 1'b0, 1'b1, 10'd0};

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t                   kind;
        cfg_idx_t                    reg_idx;
        logic [CFG_DATA_W-1:0]       wdata;
        logic signed [LOAD_BITS-1:0] load;
        logic                        arm;
        logic                        abort;
        logic                        typed;
        result_t                     want;
    } plan_row_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        s_valid;
    logic                        s_ready;
    logic signed [LOAD_BITS-1:0] s_load;
    logic                        s_arm;
    logic                        s_abort;
    logic                        m_valid;
    logic                        m_ready;
    logic [PHASE_BITS-1:0]       m_phase;
    logic                        m_pyro_fire;
    logic                        m_log_enable;
    logic [IVL_BITS-1:0]         m_log_interval_ms;

    // register mirror
    logic [CNT_BITS-1:0]        reg_countdown;
    logic signed [THR_BITS-1:0] reg_threshold;
    logic [CNT_BITS-1:0]        reg_data_safe;
    logic [IVL_BITS-1:0]        reg_slow_ivl;
    logic [IVL_BITS-1:0]        reg_fast_ivl;

    // sequencer state as predicted
    phase_t              seq_phase;
    logic                arm_seen;
    logic [CNT_BITS-1:0] countdown_cnt;
    logic [CNT_BITS-1:0] safe_cnt;
    logic                fast_log;
    longint              window_samples [AVG_WINDOW];
    int                  window_idx;
    int                  window_count;
    longint              window_total;

    result_t     expected_status [$];
    plan_row_t   directed_plan [24];
    bit          steady;
    bit          hold_request;
    int unsigned error_count;
    int unsigned ticks_sent;
    int unsigned results_checked;
    int unsigned reg_writes;
    int unsigned phase_hits [8];

    motor_test_fire_sequencer u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_load            (s_load),
        .s_arm             (s_arm),
        .s_abort           (s_abort),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_phase           (m_phase),
        .m_pyro_fire       (m_pyro_fire),
        .m_log_enable      (m_log_enable),
        .m_log_interval_ms (m_log_interval_ms)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("ERROR: run timed out with %0d results outstanding", expected_status.size());
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        error_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic result_t step_sequencer(input logic signed [LOAD_BITS-1:0] load,
                                               input logic arm, input logic abort);
        result_t r;
        logic    pyro;
        longint  thr_l;
        longint  load_l;
        pyro   = 1'b0;
        thr_l  = longint'(reg_threshold);
        load_l = longint'(load);
        if (arm) arm_seen = 1'b1;
        if (abort) begin
            seq_phase = PH_ABORT;
        end else begin
            case (seq_phase)
                PH_STANDBY: begin
                    if (arm_seen) begin
                        countdown_cnt = reg_countdown;
                        seq_phase     = PH_COUNTDOWN;
                    end
                end
                PH_COUNTDOWN: begin
                    if (countdown_cnt == 0) seq_phase = PH_IGNITION;
                    else countdown_cnt--;
                end
                PH_IGNITION: begin
                    fast_log = 1'b1;
                    pyro     = 1'b1;
                    if (load_l > thr_l) seq_phase = PH_BURN;
                end
                PH_BURN: begin
                    // drop the oldest sample only once the window is full
                    if (window_count >= AVG_WINDOW)
                        window_total -= window_samples[window_idx];
                    window_total += load_l;
                    window_samples[window_idx] = load_l;
                    window_idx = (window_idx + 1) % AVG_WINDOW;
                    if (window_count < AVG_WINDOW) window_count++;
                    if (window_total < thr_l * window_count) begin
                        safe_cnt  = reg_data_safe;
                        seq_phase = PH_SAFE;
                    end
                end
                PH_SAFE: begin
                    if (load_l > thr_l) seq_phase = PH_BURN;
                    else if (safe_cnt == 0) seq_phase = PH_ENDED;
                    else safe_cnt--;
                end
                default: ;
            endcase
        end
        r.phase           = seq_phase;
        r.pyro_fire       = pyro;
        r.log_enable      = (seq_phase >= PH_COUNTDOWN) && (seq_phase <= PH_SAFE);
        r.log_interval_ms = fast_log ? reg_fast_ivl : reg_slow_ivl;
        return r;
    endfunction

    // Mostly near the threshold so burn and data-safe keep trading places.
    function automatic logic signed [LOAD_BITS-1:0] pick_load();
        longint                      thr_l;
        longint                      v;
        logic signed [LOAD_BITS-1:0] raw;
        thr_l = longint'(reg_threshold);
        raw   = LOAD_BITS'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = thr_l + longint'($urandom_range(0, 8)) - 4;
            5, 6:          v = thr_l + longint'($urandom_range(0, 4000)) - 2000;
            7:             v = raw;
            8:             v = $urandom_range(0, 1) ? LOAD_MAX : LOAD_MIN;
            default:       v = thr_l + 1;
        endcase
        // keep the firing alive: an expired data-safe timer needs thrust
        if (seq_phase == PH_SAFE && safe_cnt == 0 && v <= thr_l)
            v = thr_l + 1 + longint'($urandom_range(0, 50));
        if (v > LOAD_MAX) v = LOAD_MAX;
        if (v < LOAD_MIN) v = LOAD_MIN;
        return LOAD_BITS'(v);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_interval();
        case ($urandom_range(0, 5))
            0:       return CFG_DATA_W'(1);
            1:       return CFG_DATA_W'(1000);
            2:       return CFG_DATA_W'(0);
            3:       return CFG_DATA_W'(1023);
            default: return CFG_DATA_W'($urandom_range(1, 1000));
        endcase
    endfunction

    task automatic send_tick(input logic signed [LOAD_BITS-1:0] load, input logic arm,
                             input logic abort, input logic typed, input result_t want);
        int      gap;
        result_t predicted;
        gap = (steady || $urandom_range(0, 1)) ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_load  <= load;
        s_arm   <= arm;
        s_abort <= abort;
        do @(posedge aclk); while (!s_ready);
        predicted = step_sequencer(load, arm, abort);
        expected_status.push_back(typed ? want : predicted);
        phase_hits[predicted.phase]++;
        ticks_sent++;
    endtask

    // Write only with nothing in flight.
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        s_valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_COUNTDOWN: reg_countdown = data[CNT_BITS-1:0];
            REG_THRESHOLD: reg_threshold = data[THR_BITS-1:0];
            REG_DATA_SAFE: reg_data_safe = data[CNT_BITS-1:0];
            REG_SLOW_IVL:  reg_slow_ivl  = data[IVL_BITS-1:0];
            REG_FAST_IVL:  reg_fast_ivl  = data[IVL_BITS-1:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge aclk);
    endtask

    task automatic setup_phase();
        logic signed [LOAD_BITS-1:0] thr_pick;
        logic [CNT_BITS-1:0]         safe_pick;
        logic [CNT_BITS-1:0]         cd_pick;
        case ($urandom_range(0, 4))
            0: thr_pick = LOAD_BITS'(int'($urandom_range(0, 40)) - 20);
            1: begin
                thr_pick = LOAD_BITS'($urandom);
                if (thr_pick == LOAD_TOP) thr_pick = LOAD_TOP - 24'sd1;
            end
            2:       thr_pick = LOAD_BOTTOM;
            3:       thr_pick = '0;
            default: thr_pick = LOAD_BITS'(int'($urandom_range(0, 200000)) - 100000);
        endcase
        case ($urandom_range(0, 4))
            0:       safe_pick = '0;
            1:       safe_pick = CNT_BITS'(1);
            2:       safe_pick = CNT_BITS'($urandom_range(0, 40));
            3:       safe_pick = '1;
            default: safe_pick = CNT_BITS'($urandom_range(0, 8));
        endcase
        case ($urandom_range(0, 2))
            0:       cd_pick = '0;
            1:       cd_pick = '1;
            default: cd_pick = CNT_BITS'($urandom);
        endcase
        write_reg(REG_THRESHOLD, thr_pick);
        write_reg(REG_DATA_SAFE, CFG_DATA_W'(safe_pick));
        write_reg(REG_SLOW_IVL, pick_interval());
        write_reg(REG_FAST_IVL, pick_interval());
        write_reg(REG_COUNTDOWN, CFG_DATA_W'(cd_pick));
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int      stall_left;
        result_t want;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    report_mismatch($sformatf("result with no tick pending, phase %0d", m_phase));
                end else begin
                    want = expected_status.pop_front();
                    if (m_phase !== want.phase)
                        report_mismatch($sformatf("result %0d phase: got %0d, expected %0d",
                                                  results_checked, m_phase, want.phase));
                    if (m_pyro_fire !== want.pyro_fire)
                        report_mismatch($sformatf("result %0d pyro_fire: got %0b, expected %0b",
                                                  results_checked, m_pyro_fire, want.pyro_fire));
                    if (m_log_enable !== want.log_enable)
                        report_mismatch($sformatf("result %0d log_enable: got %0b, expected %0b",
                                                  results_checked, m_log_enable,
                                                  want.log_enable));
                    if (m_log_interval_ms !== want.log_interval_ms)
                        report_mismatch($sformatf("result %0d log_interval: got %0d, expected %0d",
                                                  results_checked, m_log_interval_ms,
                                                  want.log_interval_ms));
                end
                results_checked++;
            end
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (!steady && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                stall_left = pick_gap() - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_COUNTDOWN;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_load    <= '0;
        s_arm     <= 1'b0;
        s_abort   <= 1'b0;

        reg_countdown = COUNTDOWN_RST;
        reg_threshold = THRESHOLD_RST;
        reg_data_safe = DATA_SAFE_RST;
        reg_slow_ivl  = SLOW_IVL_RST;
        reg_fast_ivl  = FAST_IVL_RST;
        seq_phase     = PH_STANDBY;
        arm_seen      = 1'b0;
        countdown_cnt = '0;
        safe_cnt      = '0;
        fast_log      = 1'b0;
        window_idx    = 0;
        window_count  = 0;
        window_total  = 0;
        steady        = 1'b0;
        hold_request  = 1'b0;
        foreach (phase_hits[i]) phase_hits[i] = 0;

        // threshold stays at its reset value of 10 throughout the plan
        directed_plan = '{
            '{ROW_TICK,  REG_COUNTDOWN, 24'd0,    24'sd0,      1'b0, 1'b0, 1'b1, WANT_IDLE},
            '{ROW_TICK,  REG_COUNTDOWN, 24'd0,    LOAD_TOP,    1'b0, 1'b0, 1'b1, WANT_IDLE},
            '{ROW_TICK,  REG_COUNTDOWN, 24'd0,    LOAD_BOTTOM, 1'b0, 1'b0, 1'b1, WANT_IDLE},
            '{ROW_WRITE, REG_COUNTDOWN, 24'd2,    24'sd0,      1'b0, 1'b0, 1'b0, NO_WANT},
            '{ROW_WRITE, REG_SLOW_IVL,  24'd0,    24'sd0,      1'b0, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK,  REG_COUNTDOWN, 24'd0,    24'sd0,      1'b1, 1'b0, 1'b1, WANT_ARMED},
            '{ROW_TICK,  REG_COUNTDOWN, 24'd0,    24'sd5,      1'b0, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK,  REG_COUNTDOWN, 24'd0,    24'sd0,      1'b1, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK,  REG_COUNTDOWN, 24'd0,    24'sd0,      1'b0, 1'b0, 1'b0, NO_WANT},
            // load equal to the threshold keeps the pyro firing
            '{ROW_TICK,  REG_COUNTDOWN, 24'd0,    24'sd10,     1'b0, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK,  REG_COUNTDOWN, 24'd0,    LOAD_BOTTOM, 1'b0, 1'b0, 1'b0, NO_WANT},
            '{ROW_WRITE, REG_FAST_IVL,  24'd1023, 24'sd0,      1'b0, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK,  REG_COUNTDOWN, 24'd0,    24'sd11,     1'b0, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK,  REG_COUNTDOWN, 24'd0,    24'sd100,    1'b0, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK,  REG_COUNTDOWN, 24'd0,    24'sd10,     1'b0, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK,  REG_COUNTDOWN, 24'd0,    -24'sd200,   1'b0, 1'b0, 1'b0, NO_WANT},
            // thrust with the data-safe timer already expired returns to burn
            '{ROW_TICK,  REG_COUNTDOWN, 24'd0,    LOAD_TOP,    1'b0, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK,  REG_COUNTDOWN, 24'd0,    24'sd0,      1'b0, 1'b0, 1'b0, NO_WANT},
            '{ROW_WRITE, REG_DATA_SAFE, 24'd2,    24'sd0,      1'b0, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK,  REG_COUNTDOWN, 24'd0,    24'sd50,     1'b0, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK,  REG_COUNTDOWN, 24'd0,    -24'sd100,   1'b0, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK,  REG_COUNTDOWN, 24'd0,    24'sd10,     1'b0, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK,  REG_COUNTDOWN, 24'd0,    24'sd0,      1'b0, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK,  REG_COUNTDOWN, 24'd0,    24'sd11,     1'b0, 1'b0, 1'b0, NO_WANT}
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == ROW_WRITE)
                write_reg(directed_plan[i].reg_idx, directed_plan[i].wdata);
            else
                send_tick(directed_plan[i].load, directed_plan[i].arm, directed_plan[i].abort,
                          directed_plan[i].typed, directed_plan[i].want);
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            steady = 1'b0;
            setup_phase();
            steady = (p % 3 == 2);
            // stall the result side long enough to back up the tick input
            if (p == 3) hold_request = 1'b1;
            repeat (PHASE_TICKS)
                send_tick(pick_load(), $urandom_range(0, 7) == 0, 1'b0, 1'b0, NO_WANT);
        end

        // top threshold: thrust can no longer be seen, so the firing ends
        steady = 1'b0;
        write_reg(REG_THRESHOLD, LOAD_TOP);
        write_reg(REG_DATA_SAFE, CFG_DATA_W'(3));
        repeat (40)
            send_tick(LOAD_BITS'($urandom), 1'($urandom_range(0, 1)), 1'b0, 1'b0, NO_WANT);
        send_tick(LOAD_BITS'($urandom), 1'b1, 1'b1, 1'b0, NO_WANT);
        repeat (10)
            send_tick(LOAD_BITS'($urandom), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'b0, NO_WANT);

        s_valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Summary: %0d ticks, %0d results checked, %0d register writes",
                 ticks_sent, results_checked, reg_writes);
        $display("Summary: ticks in countdown %0d, ignition %0d, burn %0d, data-safe %0d, %s",
                 phase_hits[PH_COUNTDOWN], phase_hits[PH_IGNITION], phase_hits[PH_BURN],
                 phase_hits[PH_SAFE],
                 $sformatf("ended %0d, abort %0d", phase_hits[PH_ENDED], phase_hits[PH_ABORT]));
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
